FILE: src/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types, constants and decode functions for the seven-segment scan
// controller.
// ----------------------------------------------------------------------------
`default_nettype none

package ssc_pkg;

    localparam int DIGIT_COUNT = 4;
    localparam int IDX_W       = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

    localparam logic [1:0] CMD_WRITE_CHAR  = 2'd0;
    localparam logic [1:0] CMD_SHOW_NUMBER = 2'd1;
    localparam logic [1:0] CMD_BLANK_ALL   = 2'd2;
    localparam logic [1:0] CMD_SCAN_TICK   = 2'd3;

    localparam logic [7:0] SEG_BLANK = 8'hFF;

    // Glyph table: hex digits, then r, U, u, P, o, N, n, minus and blank.
    localparam logic [7:0] GLYPHS [25] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8,
        8'h80, 8'h90, 8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E,
        8'hAF, 8'hC1, 8'hE3, 8'h8C, 8'hA3, 8'hC8, 8'hAB, 8'hBF, 8'hFF
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NUMBER,
        ST_BLANK
    } t_state;

    function automatic logic [7:0] select_byte(input logic [IDX_W-1:0] pos);
        logic [2:0] sh;
        sh = 3'(DIGIT_COUNT - 1) - 3'(pos);
        return ~(8'd1 << sh);
    endfunction

    function automatic logic [7:0] digit_glyph(input logic [3:0] d);
        return GLYPHS[d];
    endfunction

    function automatic logic [7:0] decode_char(input logic [7:0] c);
        logic [7:0] seg;
        if (c >= "0" && c <= "9") begin
            seg = GLYPHS[5'(c - "0")];
        end else if (c >= "a" && c <= "f") begin
            seg = GLYPHS[5'(c - "a" + 8'd10)];
        end else if (c >= "A" && c <= "F") begin
            seg = GLYPHS[5'(c - "A" + 8'd10)];
        end else begin
            case (c)
                "r", "R": seg = GLYPHS[16];
                "U":      seg = GLYPHS[17];
                "u":      seg = GLYPHS[18];
                "p", "P": seg = GLYPHS[19];
                "o", "O": seg = GLYPHS[20];
                "N":      seg = GLYPHS[21];
                "n":      seg = GLYPHS[22];
                "-":      seg = GLYPHS[23];
                default:  seg = GLYPHS[24];
            endcase
        end
        return seg;
    endfunction

endpackage

`default_nettype wire

FILE: src/ssc_div10.sv
// ----------------------------------------------------------------------------
// ssc_div10
// Divide-by-ten unit: one quotient and decimal remainder per use, by a
// reciprocal multiply and a multiply-back for the remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_div10 (
    input  wire logic [15:0] i_dividend,
    output logic      [15:0] o_quotient,
    output logic      [3:0]  o_remainder
);

    // ceil(2^19 / 10); exact for every 16-bit dividend.
    localparam logic [32:0] RECIP = 33'd52429;

    logic [32:0] w_prod;
    logic [15:0] w_back;

    assign w_prod      = 33'(i_dividend) * RECIP;
    assign o_quotient  = {2'b00, w_prod[32:19]};
    assign w_back      = {o_quotient[12:0], 3'b000} + {o_quotient[14:0], 1'b0};
    assign o_remainder = 4'(i_dividend - w_back);

endmodule

`default_nettype wire

FILE: src/seven_segment_scan_controller_core.sv
// ----------------------------------------------------------------------------
// seven_segment_scan_controller_core
// Four-digit multiplexed seven-segment controller: character writes, decimal
// number display, blanking and scan-tick output of the digit words.
// ----------------------------------------------------------------------------
// Write-character and scan-tick requests leave the controller idle; a scan tick's word
// is in the output register in the cycle after acceptance.
// Show-number writes the decimal digits in turn, units at position 0, through the divide-by-ten
// unit while ready is low; blank-all clears one position per cycle.
// Reset is synchronous: all positions hold blank words, the scan pointer is 0.
`default_nettype none

module seven_segment_scan_controller_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_command,
    input  wire logic [7:0]  i_char_code,
    input  wire logic [1:0]  i_position,
    input  wire logic        i_dot,
    input  wire logic [15:0] i_number,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic      [15:0] o_frame_word,
    output logic      [1:0]  o_digit_index
);

    localparam int IW = ssc_pkg::IDX_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(ssc_pkg::DIGIT_COUNT - 1);

    ssc_pkg::t_state r_state, n_state;

    logic [IW-1:0] r_cnt;
    logic [15:0]   r_num;
    logic [15:0]   r_words [ssc_pkg::DIGIT_COUNT];
    logic [IW-1:0] r_ptr;
    logic          r_out_valid;
    logic [15:0]   r_frame;
    logic [1:0]    r_oidx;

    logic          w_accept;
    logic          w_wr_en;
    logic [IW-1:0] w_wr_addr;
    logic [7:0]    w_wr_seg;
    logic [15:0]   w_quot;
    logic [3:0]    w_rem;
    logic [7:0]    w_char_seg;

    ssc_div10 u_div10 (
        .i_dividend  (r_num),
        .o_quotient  (w_quot),
        .o_remainder (w_rem)
    );

    assign w_accept   = i_valid && o_ready;
    assign w_char_seg = ssc_pkg::decode_char(i_char_code) & {~i_dot, 7'h7F};

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ssc_pkg::ST_IDLE: begin
                if (w_accept && i_command == ssc_pkg::CMD_SHOW_NUMBER) begin
                    n_state = ssc_pkg::ST_NUMBER;
                end else if (w_accept && i_command == ssc_pkg::CMD_BLANK_ALL) begin
                    n_state = ssc_pkg::ST_BLANK;
                end
            end
            ssc_pkg::ST_NUMBER,
            ssc_pkg::ST_BLANK: begin
                if (r_cnt == LAST_IDX) begin
                    n_state = ssc_pkg::ST_IDLE;
                end
            end
            default: n_state = ssc_pkg::ST_IDLE;
        endcase
    end

    // Outputs and digit-buffer write port.
    always_comb begin
        o_ready   = 1'b0;
        w_wr_en   = 1'b0;
        w_wr_addr = r_cnt;
        w_wr_seg  = ssc_pkg::SEG_BLANK;
        case (r_state)
            ssc_pkg::ST_IDLE: begin
                o_ready   = !r_out_valid || i_ready;
                w_wr_addr = IW'(i_position);
                w_wr_seg  = w_char_seg;
                w_wr_en   = w_accept && i_command == ssc_pkg::CMD_WRITE_CHAR
                            && 32'(i_position) < ssc_pkg::DIGIT_COUNT;
            end
            ssc_pkg::ST_NUMBER: begin
                w_wr_en  = 1'b1;
                w_wr_seg = ssc_pkg::digit_glyph(w_rem);
            end
            ssc_pkg::ST_BLANK: begin
                w_wr_en = 1'b1;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ssc_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < ssc_pkg::DIGIT_COUNT; i++) begin
                r_words[i] <= {ssc_pkg::select_byte(IW'(i)), ssc_pkg::SEG_BLANK};
            end
        end else begin
            r_state <= n_state;

            if (r_state == ssc_pkg::ST_IDLE) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end

            if (w_wr_en) begin
                r_words[w_wr_addr] <= {ssc_pkg::select_byte(w_wr_addr), w_wr_seg};
            end

            if (w_accept && i_command == ssc_pkg::CMD_SCAN_TICK) begin
                r_out_valid <= 1'b1;
                r_ptr       <= (r_ptr == LAST_IDX) ? '0 : r_ptr + 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept && i_command == ssc_pkg::CMD_SHOW_NUMBER) begin
            r_num <= i_number;
        end else if (r_state == ssc_pkg::ST_NUMBER) begin
            r_num <= w_quot;
        end
        if (w_accept && i_command == ssc_pkg::CMD_SCAN_TICK) begin
            r_frame <= r_words[r_ptr];
            r_oidx  <= 2'(r_ptr);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_frame_word  = r_frame;
    assign o_digit_index = r_oidx;

endmodule

`default_nettype wire

FILE: tb/tb_seven_segment_scan_controller_core.sv
// ----------------------------------------------------------------------------
// tb_seven_segment_scan_controller_core
// Self-checking bench for the seven-segment scan controller. A queue of
// directed and random requests feeds a bursty driver. A behavioral copy of the
// digit buffer and the scan pointer predicts the frame for every scan tick.
// The monitor compares each frame with the oldest prediction while the
// receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_seven_segment_scan_controller_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_CYCLES  = 500000;
    localparam int DRAIN_TAIL  = 20;
    localparam int LONG_HOLD   = 400;
    localparam int HOLD_AFTER  = 60;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  char_code;
        logic [1:0]  position;
        logic        dot;
        logic [15:0] number;
    } t_cmd_req;

    typedef struct packed {
        logic [15:0] frame_word;
        logic [1:0]  digit_index;
    } t_frame;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic        o_ready;
    logic [1:0]  i_command     = ssc_pkg::CMD_SCAN_TICK;
    logic [7:0]  i_char_code   = 8'h00;
    logic [1:0]  i_position    = 2'd0;
    logic        i_dot         = 1'b0;
    logic [15:0] i_number      = 16'h0000;
    logic        o_valid;
    logic        i_ready       = 1'b0;
    logic [15:0] o_frame_word;
    logic [1:0]  o_digit_index;

    t_cmd_req    req_q[$];
    t_frame      frame_q[$];
    t_cmd_req    req_on_bus;
    logic [15:0] digit_word [ssc_pkg::DIGIT_COUNT];
    int unsigned scan_ptr;
    int unsigned err_cnt      = 0;
    int unsigned frames_seen  = 0;

    seven_segment_scan_controller_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_command     (i_command),
        .i_char_code   (i_char_code),
        .i_position    (i_position),
        .i_dot         (i_dot),
        .i_number      (i_number),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_frame_word  (o_frame_word),
        .o_digit_index (o_digit_index)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Display model
    // ------------------------------------------------------------------
    function automatic logic [7:0] glyph_for_char(input logic [7:0] c);
        case (c)
            "0":      return 8'hC0;
            "1":      return 8'hF9;
            "2":      return 8'hA4;
            "3":      return 8'hB0;
            "4":      return 8'h99;
            "5":      return 8'h92;
            "6":      return 8'h82;
            "7":      return 8'hF8;
            "8":      return 8'h80;
            "9":      return 8'h90;
            "a", "A": return 8'h88;
            "b", "B": return 8'h83;
            "c", "C": return 8'hC6;
            "d", "D": return 8'hA1;
            "e", "E": return 8'h86;
            "f", "F": return 8'h8E;
            "r", "R": return 8'hAF;
            "U":      return 8'hC1;
            "u":      return 8'hE3;
            "p", "P": return 8'h8C;
            "o", "O": return 8'hA3;
            "N":      return 8'hC8;
            "n":      return 8'hAB;
            "-":      return 8'hBF;
            default:  return ssc_pkg::SEG_BLANK;
        endcase
    endfunction

    // Active-low select line: position 0 drives bit DIGIT_COUNT-1, the highest select bit in use.
    function automatic logic [7:0] select_pattern(input int unsigned pos);
        return ~(8'h01 << (ssc_pkg::DIGIT_COUNT - 1 - pos));
    endfunction

    task automatic clear_display();
        for (int p = 0; p < ssc_pkg::DIGIT_COUNT; p++) begin
            digit_word[p] = {select_pattern(p), ssc_pkg::SEG_BLANK};
        end
    endtask

    task automatic update_display(input t_cmd_req r);
        logic [7:0]  seg;
        int unsigned val;
        t_frame      f;
        case (r.command)
            ssc_pkg::CMD_WRITE_CHAR: begin
                if (r.position < ssc_pkg::DIGIT_COUNT) begin
                    seg = glyph_for_char(r.char_code);
                    if (r.dot) begin
                        seg[7] = 1'b0;
                    end
                    digit_word[r.position] = {select_pattern(r.position), seg};
                end
            end
            ssc_pkg::CMD_SHOW_NUMBER: begin
                // Units land at position 0; higher decimal digits are dropped.
                val = r.number;
                for (int p = 0; p < ssc_pkg::DIGIT_COUNT; p++) begin
                    seg = glyph_for_char(8'("0" + (val % 10)));
                    digit_word[p] = {select_pattern(p), seg};
                    val = val / 10;
                end
            end
            ssc_pkg::CMD_BLANK_ALL: begin
                clear_display();
            end
            default: begin
                f.frame_word  = digit_word[scan_ptr];
                f.digit_index = 2'(scan_ptr);
                frame_q.push_back(f);
                scan_ptr = (scan_ptr == ssc_pkg::DIGIT_COUNT - 1) ? 0 : scan_ptr + 1;
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_req(input logic [1:0] cmd, input logic [7:0] ch,
                           input logic [1:0] pos, input logic dt,
                           input logic [15:0] num);
        t_cmd_req r;
        r.command   = cmd;
        r.char_code = ch;
        r.position  = pos;
        r.dot       = dt;
        r.number    = num;
        req_q.push_back(r);
    endtask

    task automatic add_scans(input int n);
        for (int k = 0; k < n; k++) begin
            add_req(ssc_pkg::CMD_SCAN_TICK, 8'($urandom), 2'($urandom), 1'($urandom),
                    16'($urandom));
        end
    endtask

    task automatic add_random_reqs(input int n);
        string       known_chars;
        int unsigned pick;
        logic [1:0]  cmd;
        logic [7:0]  ch;
        logic [15:0] num;
        known_chars = "0123456789abcdefABCDEFrRUupPoONn-";
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 38)      cmd = ssc_pkg::CMD_WRITE_CHAR;
            else if (pick < 52) cmd = ssc_pkg::CMD_SHOW_NUMBER;
            else if (pick < 57) cmd = ssc_pkg::CMD_BLANK_ALL;
            else                cmd = ssc_pkg::CMD_SCAN_TICK;
            if ($urandom_range(0, 1) == 0) begin
                ch = known_chars[$urandom_range(0, known_chars.len() - 1)];
            end else begin
                ch = 8'($urandom_range(0, 255));
            end
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                num = 16'($urandom_range(0, 9999));
            end else if (pick < 85) begin
                num = 16'($urandom_range(0, 65535));
            end else begin
                case ($urandom_range(0, 3))
                    0:       num = 16'd0;
                    1:       num = 16'd9999;
                    2:       num = 16'd10000;
                    default: num = 16'hFFFF;
                endcase
            end
            add_req(cmd, ch, 2'($urandom), 1'($urandom), num);
        end
    endtask

    task automatic wait_for_drain();
        while (req_q.size() != 0 || i_valid || frame_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of requests separated by random gaps
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
            scan_ptr   = 0;
            clear_display();
        end else begin
            if (i_valid && o_ready) begin
                update_display(req_on_bus);
            end
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (req_q.size() == 0) begin
                    i_valid <= 1'b0;
                end else begin
                    req_on_bus  = req_q.pop_front();
                    i_command   <= req_on_bus.command;
                    i_char_code <= req_on_bus.char_code;
                    i_position  <= req_on_bus.position;
                    i_dot       <= req_on_bus.dot;
                    i_number    <= req_on_bus.number;
                    i_valid     <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: changing stall modes plus one long hold-off
    // ------------------------------------------------------------------
    int unsigned rx_mode        = 0;
    int unsigned rx_mode_left   = 0;
    int unsigned hold_left      = 0;
    bit          hold_done      = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (!hold_done && frames_seen >= HOLD_AFTER) begin
            // Keep the output blocked long enough for the request side to back up.
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            i_ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 2);
                rx_mode_left = $urandom_range(16, 80);
            end else begin
                rx_mode_left--;
            end
            case (rx_mode)
                0:       i_ready <= 1'b1;
                1:       i_ready <= 1'($urandom_range(0, 1));
                default: i_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_frame exp_f;
        if (i_rst_n && o_valid && i_ready) begin
            frames_seen++;
            if (frame_q.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected frame word=%h index=%0d", $time,
                         o_frame_word, o_digit_index);
            end else begin
                exp_f = frame_q.pop_front();
                if (o_frame_word !== exp_f.frame_word) begin
                    err_cnt++;
                    $display("%0t: frame_word expected %h actual %h", $time,
                             exp_f.frame_word, o_frame_word);
                end
                if (o_digit_index !== exp_f.digit_index) begin
                    err_cnt++;
                    $display("%0t: digit_index expected %0d actual %0d", $time,
                             exp_f.digit_index, o_digit_index);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Timeout
    // ------------------------------------------------------------------
    initial begin
        for (int cyc = 0; cyc < MAX_CYCLES; cyc++) begin
            @(posedge i_clk);
        end
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        // Directed: reset contents, character extremes, dots, number wrap, blanking.
        add_scans(4);
        add_req(ssc_pkg::CMD_WRITE_CHAR, "0", 2'd0, 1'b0, 16'hFFFF);
        add_req(ssc_pkg::CMD_WRITE_CHAR, 8'hFF, 2'd1, 1'b1, 16'h0000);
        add_req(ssc_pkg::CMD_WRITE_CHAR, "F", 2'd2, 1'b0, 16'h0000);
        add_req(ssc_pkg::CMD_WRITE_CHAR, "n", 2'd3, 1'b1, 16'hFFFF);
        add_scans(4);
        add_req(ssc_pkg::CMD_SHOW_NUMBER, 8'h00, 2'd0, 1'b1, 16'hFFFF);
        add_scans(4);
        add_req(ssc_pkg::CMD_SHOW_NUMBER, 8'hFF, 2'd3, 1'b0, 16'd0);
        add_scans(1);
        add_req(ssc_pkg::CMD_BLANK_ALL, "8", 2'd1, 1'b1, 16'd1234);
        add_scans(4);
        add_req(ssc_pkg::CMD_WRITE_CHAR, "-", 2'd3, 1'b1, 16'd0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_random_reqs(500);
        // The request side sits idle until every frame so far has come back.
        wait_for_drain();
        add_random_reqs(600);
        wait_for_drain();
        repeat (DRAIN_TAIL) @(posedge i_clk);

        if (err_cnt == 0 && frame_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
